>>> design/exfwd_pkg.sv
package exfwd_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned REG_W   = 5;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned SEL_W   = 2;

  localparam logic [CLASS_W-1:0] CLASS_RTYPE = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_LOAD  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_STORE = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_OTHER = 2'd3;

  localparam logic [OP_W-1:0] OP_XOR = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD = 3'd6;
  localparam logic [OP_W-1:0] OP_SUB = 3'd7;

  localparam logic [SEL_W-1:0] FWD_REG = 2'd0;
  localparam logic [SEL_W-1:0] FWD_MEM = 2'd1;
  localparam logic [SEL_W-1:0] FWD_EX  = 2'd2;

  typedef struct packed {
    logic [CLASS_W-1:0]       op_class;
    logic [OP_W-1:0]          alu_op;
    logic [REG_W-1:0]         src1_reg;
    logic [REG_W-1:0]         src2_reg;
    logic signed [DATA_W-1:0] src1_value;
    logic signed [DATA_W-1:0] operand_b;
    logic [REG_W-1:0]         dest_reg;
    logic                     writes_reg;
    logic                     mem_writes_reg;
    logic [REG_W-1:0]         mem_dest_reg;
    logic signed [DATA_W-1:0] mem_alu_result;
    logic signed [DATA_W-1:0] mem_load_data;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] alu_result;
    logic                     negative;
    logic                     zero;
    logic [REG_W-1:0]         out_dest_reg;
    logic                     out_writes_reg;
    logic [CLASS_W-1:0]       out_op_class;
    logic [SEL_W-1:0]         forward_a_sel;
    logic [SEL_W-1:0]         forward_b_sel;
  } out_item_t;

  // producer state seen by the forwarding mux
  typedef struct packed {
    logic [DATA_W-1:0]  ex_result;
    logic [REG_W-1:0]   ex_dest;
    logic               ex_writes;
    logic [CLASS_W-1:0] ex_class;
    logic               mem_writes;
    logic [REG_W-1:0]   mem_dest;
    logic [DATA_W-1:0]  mem_result;
    logic [DATA_W-1:0]  mem_data;
  } fwd_state_t;

endpackage

>>> design/exfwd_chan_if.sv
interface exfwd_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/exfwd_fwd.sv
module exfwd_fwd
  import exfwd_pkg::*;
(
  input  fwd_state_t         st,
  input  logic [CLASS_W-1:0] op_class,
  input  logic [REG_W-1:0]   src1_reg,
  input  logic [REG_W-1:0]   src2_reg,
  input  logic [DATA_W-1:0]  src1_value,
  input  logic [DATA_W-1:0]  operand_b,
  output logic [DATA_W-1:0]  opnd_a,
  output logic [DATA_W-1:0]  opnd_b,
  output logic [SEL_W-1:0]   sel_a,
  output logic [SEL_W-1:0]   sel_b
);

  logic              ex_hit_a;
  logic              ex_hit_b;
  logic              mem_hit_a;
  logic              mem_hit_b;
  logic              ex_b_ok;
  logic              mem_b_ok;
  logic [DATA_W-1:0] ex_val;

  assign ex_hit_a  = st.ex_writes && (st.ex_dest == src1_reg);
  assign ex_hit_b  = st.ex_writes && (st.ex_dest == src2_reg);
  assign mem_hit_a = st.mem_writes && (st.mem_dest == src1_reg);
  assign mem_hit_b = st.mem_writes && (st.mem_dest == src2_reg);
  assign ex_b_ok   = (st.ex_class == CLASS_RTYPE) || (st.ex_class == CLASS_LOAD);
  assign mem_b_ok  = (op_class != CLASS_LOAD) && (op_class != CLASS_STORE);

  // a load still in execute forwards its loaded word
  assign ex_val = (st.ex_class == CLASS_LOAD) ? st.mem_data : st.ex_result;

  always_comb begin
    if (ex_hit_a) begin
      sel_a = FWD_EX;
    end else if (mem_hit_a) begin
      sel_a = FWD_MEM;
    end else begin
      sel_a = FWD_REG;
    end

    if (mem_hit_b && !ex_hit_b && mem_b_ok) begin
      sel_b = FWD_MEM;
    end else if (ex_hit_b && ex_b_ok) begin
      sel_b = FWD_EX;
    end else begin
      sel_b = FWD_REG;
    end
  end

  always_comb begin
    case (sel_a)
      FWD_EX:  opnd_a = ex_val;
      FWD_MEM: opnd_a = st.mem_result;
      default: opnd_a = src1_value;
    endcase
    case (sel_b)
      FWD_EX:  opnd_b = ex_val;
      FWD_MEM: opnd_b = st.mem_result;
      default: opnd_b = operand_b;
    endcase
  end

endmodule

>>> design/exfwd_alu.sv
module exfwd_alu
  import exfwd_pkg::*;
(
  input  logic [OP_W-1:0]   alu_op,
  input  logic [DATA_W-1:0] opnd_a,
  input  logic [DATA_W-1:0] opnd_b,
  input  logic [DATA_W-1:0] held,
  output logic [DATA_W-1:0] result,
  output logic              negative,
  output logic              zero
);

  always_comb begin
    case (alu_op)
      OP_ADD:  result = opnd_a + opnd_b;
      OP_XOR:  result = opnd_a ^ opnd_b;
      OP_SUB:  result = opnd_a - opnd_b;
      default: result = held;
    endcase
  end

  assign negative = result[DATA_W-1];
  assign zero     = (result == '0);

endmodule

>>> design/execute_stage_with_forwarding_unit.sv
// channel | modport | payload    | transfer
// in_ch   | sink    | in_item_t  | valid && ready at rising clk
// out_ch  | source  | out_item_t | valid && ready at rising clk
//
// One instruction per cycle unless out_ch stalls; result comes in the next cycle.
// It is held in the single result register after the forwarding mux and ALU.
// rst_n (synchronous, low) clears the execute and memory snapshot state to zero.
// in_ch.ready drops only while a result is held and out_ch.ready is low.
module execute_stage_with_forwarding_unit
  import exfwd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  exfwd_chan_if.sink               in_ch,
  exfwd_chan_if.source             out_ch
);

  fwd_state_t        st_r;
  fwd_state_t        st_nxt;
  out_item_t         out_r;
  out_item_t         out_nxt;
  logic              out_valid_r;
  logic              in_acc;
  logic [DATA_W-1:0] opnd_a;
  logic [DATA_W-1:0] opnd_b;
  logic [SEL_W-1:0]  sel_a;
  logic [SEL_W-1:0]  sel_b;
  logic [DATA_W-1:0] alu_res;
  logic              alu_neg;
  logic              alu_zero;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  exfwd_fwd u_fwd (
    .st         (st_r),
    .op_class   (in_ch.data.op_class),
    .src1_reg   (in_ch.data.src1_reg),
    .src2_reg   (in_ch.data.src2_reg),
    .src1_value (in_ch.data.src1_value),
    .operand_b  (in_ch.data.operand_b),
    .opnd_a     (opnd_a),
    .opnd_b     (opnd_b),
    .sel_a      (sel_a),
    .sel_b      (sel_b)
  );

  exfwd_alu u_alu (
    .alu_op   (in_ch.data.alu_op),
    .opnd_a   (opnd_a),
    .opnd_b   (opnd_b),
    .held     (st_r.ex_result),
    .result   (alu_res),
    .negative (alu_neg),
    .zero     (alu_zero)
  );

  always_comb begin
    st_nxt.ex_result  = alu_res;
    st_nxt.ex_dest    = in_ch.data.dest_reg;
    st_nxt.ex_writes  = in_ch.data.writes_reg;
    st_nxt.ex_class   = in_ch.data.op_class;
    st_nxt.mem_writes = in_ch.data.mem_writes_reg;
    st_nxt.mem_dest   = in_ch.data.mem_dest_reg;
    st_nxt.mem_result = in_ch.data.mem_alu_result;
    st_nxt.mem_data   = in_ch.data.mem_load_data;

    out_nxt.alu_result     = alu_res;
    out_nxt.negative       = alu_neg;
    out_nxt.zero           = alu_zero;
    out_nxt.out_dest_reg   = in_ch.data.dest_reg;
    out_nxt.out_writes_reg = in_ch.data.writes_reg;
    out_nxt.out_op_class   = in_ch.data.op_class;
    out_nxt.forward_a_sel  = sel_a;
    out_nxt.forward_b_sel  = sel_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("transaction accepted without a result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_mem_fwd_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.forward_b_sel == FWD_MEM) |->
      (out_r.out_op_class != CLASS_LOAD && out_r.out_op_class != CLASS_STORE))
    else $error("operand B forwarded from memory for load or store");

  a_state_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (st_r.ex_result == out_r.alu_result &&
                     st_r.ex_dest == out_r.out_dest_reg))
    else $error("held execute state differs from delivered result");

endmodule
